>>> hw/rtl/iprl_pkg.sv
// Shared types and constants for the IPv4 range location lookup block.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package iprl_pkg;

   // Request command codes
   localparam logic [1:0] CMD_LOOKUP      = 2'd0;
   localparam logic [1:0] CMD_LOAD_PREFIX = 2'd1;
   localparam logic [1:0] CMD_LOAD_RECORD = 2'd2;

   // Register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_RECORD_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INDEX_BYTES  = 2'd1;

   // Field widths
   localparam int IP_W          = 32;
   localparam int REC_NUM_W     = 16;
   localparam int LIMIT_W       = 17;
   localparam int INDEX_BYTES_W = 21;
   localparam int OFFSET_W      = 24;
   localparam int LEN_W         = 8;
   localparam int ADDR_W        = 25;
   localparam int REC_W         = IP_W + OFFSET_W + LEN_W;

   localparam int PREFIX_ENTRIES = 256;
   localparam int PREFIX_W       = 8;

   localparam logic [INDEX_BYTES_W-1:0] INDEX_BYTES_RESET = 21'd1028;
   localparam logic [ADDR_W-1:0]        TEXT_BIAS         = 25'd1024;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [IP_W-1:0]      ip_address;
      logic [REC_NUM_W-1:0] slot;
      logic [REC_NUM_W-1:0] start_record;
      logic [OFFSET_W-1:0]  entry_offset;
      logic [LEN_W-1:0]     entry_length;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] text_address;
      logic [LEN_W-1:0]  text_length;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;      // request taken this cycle
      logic start_scan;  // prefix entry is on the RAM output
      logic issue;       // read the record at the scan pointer
      logic finish;      // load the response register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_lookup;
      logic hit;
      logic in_range;
      logic out_free;
   } dp_status_type;

endpackage

>>> hw/rtl/iprl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module iprl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/iprl_ctrl.sv
// Lookup sequencer: request handshake and scan control.
// Depends on iprl_pkg; drives the datapath through ctrl_cmd_type.
`timescale 1ns / 1ps

module iprl_ctrl
   import iprl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_PREFIX = 3'b010,
      ST_SCAN   = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      done;

   // Scan ends on a hit or when the pointer leaves the allowed range
   assign done = status.hit || !status.in_range;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_stall      = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && status.is_lookup) begin
               state_in = ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            cmd.start_scan = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (!done) begin
               cmd.issue = 1'b1;
            end else if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/iprl_dp.sv
// Datapath: config registers, prefix table and record store RAMs, scan
// pointer, match compare and response register. Depends on iprl_pkg, iprl_ram.
`timescale 1ns / 1ps

module iprl_dp
   import iprl_pkg::*;
#(
   parameter int MAX_RECORDS = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status
);

   localparam int RW = $clog2(MAX_RECORDS);
   localparam logic [31:0] MAX_REC_W = 32'(MAX_RECORDS);

   logic [LIMIT_W-1:0]       limit_ff;
   logic [INDEX_BYTES_W-1:0] index_bytes_ff;
   logic [IP_W-1:0]          ip_ff;
   logic [LIMIT_W-1:0]       ptr_ff, ptr_in;
   logic                     pend_ff, pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                prefix_wr, record_wr, prefix_rd;
   logic [REC_NUM_W-1:0] prefix_q;
   logic [REC_W-1:0]    record_q;
   logic [IP_W-1:0]     rec_end;
   logic [OFFSET_W-1:0] rec_offset;
   logic [LEN_W-1:0]    rec_length;
   logic [ADDR_W-1:0]   text_addr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= '0;
         index_bytes_ff <= INDEX_BYTES_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_RECORD_LIMIT) begin
            limit_ff <= csr_data[LIMIT_W-1:0];
         end
         if (csr_index == REG_INDEX_BYTES) begin
            index_bytes_ff <= csr_data[INDEX_BYTES_W-1:0];
         end
      end
   end

   assign status.is_lookup = (req_data.cmd == CMD_LOOKUP);
   assign prefix_rd = cmd.accept && status.is_lookup;
   assign prefix_wr = cmd.accept && (req_data.cmd == CMD_LOAD_PREFIX)
                      && (req_data.slot[REC_NUM_W-1:PREFIX_W] == '0);
   assign record_wr = cmd.accept && (req_data.cmd == CMD_LOAD_RECORD)
                      && (32'(req_data.slot) < MAX_REC_W);

   iprl_ram #(
      .WIDTH(REC_NUM_W),
      .DEPTH(PREFIX_ENTRIES)
   ) u_prefix_ram (
      .clock  (clock),
      .wr_en  (prefix_wr),
      .wr_addr(req_data.slot[PREFIX_W-1:0]),
      .wr_data(req_data.start_record),
      .rd_en  (prefix_rd),
      .rd_addr(req_data.ip_address[IP_W-1 -: PREFIX_W]),
      .rd_data(prefix_q)
   );

   iprl_ram #(
      .WIDTH(REC_W),
      .DEPTH(MAX_RECORDS)
   ) u_record_ram (
      .clock  (clock),
      .wr_en  (record_wr),
      .wr_addr(RW'(req_data.slot)),
      .wr_data({req_data.ip_address, req_data.entry_offset, req_data.entry_length}),
      .rd_en  (cmd.issue),
      .rd_addr(RW'(ptr_ff)),
      .rd_data(record_q)
   );

   assign rec_end    = record_q[REC_W-1 -: IP_W];
   assign rec_offset = record_q[LEN_W +: OFFSET_W];
   assign rec_length = record_q[LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (prefix_rd) begin
         ip_ff <= req_data.ip_address;
      end
   end

   // pend_ff marks that record_q holds the record just before ptr_ff
   assign status.hit      = pend_ff && (rec_end >= ip_ff);
   assign status.in_range = (ptr_ff < limit_ff) && (32'(ptr_ff) < MAX_REC_W);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign text_addr = ADDR_W'(index_bytes_ff) + ADDR_W'(rec_offset) - TEXT_BIAS;

   always_comb begin
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.start_scan) begin
         ptr_in  = LIMIT_W'(prefix_q);
         pend_in = 1'b0;
      end
      if (cmd.issue) begin
         ptr_in  = ptr_ff + LIMIT_W'(1);
         pend_in = 1'b1;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (status.hit) begin
            rsp_in.found        = 1'b1;
            rsp_in.text_address = text_addr;
            rsp_in.text_length  = rec_length;
         end else begin
            rsp_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("response not raised after finish");
   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("response overwritten while stalled");
   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> status.in_range && !status.hit)
      else $error("record read issued past scan bound or after hit");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.found |-> rsp_ff.text_address == '0 &&
      rsp_ff.text_length == '0)
      else $error("miss response carries nonzero fields");
`endif

endmodule

>>> hw/rtl/ip_range_location_lookup_core.sv
// Lookup flow: an accepted lookup reads the prefix table, then the scan reads
// records one per cycle through the record store read port, from the prefix
// start up to the first match or bound; the response register is then loaded
// and rsp_valid raised once it is free. Requests stall until a lookup ends;
// loads are taken back to back. Synchronous active-high reset clears control
// and config registers; the prefix table and record store are not cleared.
`timescale 1ns / 1ps

module ip_range_location_lookup_core
   import iprl_pkg::*;
#(
   parameter int MAX_RECORDS = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   iprl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   iprl_dp #(
      .MAX_RECORDS(MAX_RECORDS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .status   (status)
   );

endmodule
